// ===== src/coap_opt_pkg.sv =====
// types and constants shared by the coap option header parser
`timescale 1ns / 1ps

package coap_opt_pkg;

    // parse phases, one-hot
    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_DEXT1   = 8'b0000_0010,
        PH_DEXT_HI = 8'b0000_0100,
        PH_DEXT_LO = 8'b0000_1000,
        PH_LEXT1   = 8'b0001_0000,
        PH_LEXT_HI = 8'b0010_0000,
        PH_LEXT_LO = 8'b0100_0000,
        PH_VALUE   = 8'b1000_0000
    } phase_t;

    // byte classes
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_VALUE   = 2'd1;
    localparam logic [1:0] CLS_ERROR   = 2'd2;
    localparam logic [1:0] CLS_DISCARD = 2'd3;

    // error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_RESERVED  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    // nibble codes
    localparam logic [3:0] NIB_EXT_ONE = 4'd13;
    localparam logic [3:0] NIB_EXT_TWO = 4'd14;
    localparam logic [3:0] NIB_RSVD    = 4'd15;

    // extension biases and the 16-bit ceiling
    localparam logic [16:0] EXT_ONE_BIAS = 17'd13;
    localparam logic [16:0] EXT_TWO_BIAS = 17'd269;
    localparam logic [16:0] LEN_MAX      = 17'd65535;
    localparam logic [17:0] NUM_MAX      = 18'd65535;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
        logic       last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  byte_class;
        logic [7:0]  value_byte;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic        header_complete;
        logic        option_complete;
        logic [1:0]  error_kind;
    } result_t;

    // parser state summary for the top level
    typedef struct packed {
        logic error_seen;
        logic phase_header;
    } status_t;

endpackage

// ===== src/coap_opt_if.sv =====
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps

interface coap_opt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/coap_option_header_parser.sv =====
// Parses the option area of a CoAP message one byte per request: each byte
// yields one result with its class, the absolute option number and value
// length once the header is complete, and an error kind for a reserved
// nibble, a buffer that ends inside an option, or a number or length above
// 65535. After an error, bytes are discarded until first_of_message is set.
// Throughput is one byte per clock while result_ch.ready does not stall it;
// a byte goes from acceptance into the input register, then is decoded
// into the result register. The running option number is updated in the same
// cycle as that load, so consecutive bytes follow each other without bubbles.
`timescale 1ns / 1ps

module coap_option_header_parser (
    input  logic      clk,
    input  logic      rst_n,
    coap_opt_if.sink   item_ch,
    coap_opt_if.source result_ch
);

    logic                   in_valid_reg;
    coap_opt_pkg::in_item_t in_item_reg;
    logic                   out_valid_reg;
    coap_opt_pkg::result_t  out_res_reg;

    logic                   advance;
    coap_opt_pkg::result_t  dec_result;
    coap_opt_pkg::status_t  dec_status;

    // input register moves to the result register when that one is free
    assign advance       = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign item_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ch.ready)
        begin
            in_valid_reg <= item_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            in_item_reg <= item_ch.payload;
        end
    end

    coap_opt_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (dec_result),
        .status (dec_status)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ch.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= dec_result;
        end
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = out_res_reg;

`ifndef ASSERT_OFF
    // a decoded byte always lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_ch.valid)
        else $error("decoded byte did not reach the result register");

    // an error result leaves the parser discarding
    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec_result.byte_class == coap_opt_pkg::CLS_ERROR
        |=> dec_status.error_seen)
        else $error("error result without error state");

    // a finished option returns the parser to header phase
    a_option_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec_result.option_complete |=> dec_status.phase_header)
        else $error("option complete but parser not at header");
`endif

endmodule

// ===== src/coap_opt_decode.sv =====
// option header decode: parser state and per-byte result logic
`timescale 1ns / 1ps

module coap_opt_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  coap_opt_pkg::in_item_t item,
    output coap_opt_pkg::result_t  result,
    output coap_opt_pkg::status_t  status
);

    coap_opt_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [15:0] running_reg, running_next, running_eff;
    logic [16:0] pend_delta_reg, pend_delta_next;
    logic [15:0] pend_len_reg, pend_len_next;
    logic [3:0]  len_nib_reg, len_nib_next;
    logic [7:0]  ext_high_reg, ext_high_next;
    logic [15:0] remain_reg, remain_next;
    logic        error_reg, error_next, error_eff;

    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [3:0]  lnib;
    logic        len_stage;
    logic        fin;
    logic [16:0] fin_delta;
    logic [16:0] fin_len;
    logic [17:0] sum;
    logic        raise;
    logic [1:0]  kind;
    logic [15:0] rem_dec;

    // next state and result for the byte in the input register
    always_comb
    begin
        dn = item.data_byte[7:4];
        ln = item.data_byte[3:0];

        // a message start clears the running number and the error
        phase_eff   = item.first_of_message ? coap_opt_pkg::PH_HEADER : phase_reg;
        running_eff = item.first_of_message ? 16'd0 : running_reg;
        error_eff   = item.first_of_message ? 1'b0 : error_reg;

        phase_next      = phase_eff;
        running_next    = running_eff;
        error_next      = error_eff;
        pend_delta_next = pend_delta_reg;
        pend_len_next   = pend_len_reg;
        len_nib_next    = len_nib_reg;
        ext_high_next   = ext_high_reg;
        remain_next     = remain_reg;

        lnib      = len_nib_reg;
        len_stage = 1'b0;
        fin       = 1'b0;
        fin_delta = pend_delta_reg;
        fin_len   = 17'd0;
        sum       = 18'd0;
        raise     = 1'b0;
        kind      = coap_opt_pkg::ERR_NONE;
        rem_dec   = remain_reg - 16'd1;

        result.byte_class      = coap_opt_pkg::CLS_HEADER;
        result.value_byte      = item.data_byte;
        result.option_number   = 16'd0;
        result.option_length   = 16'd0;
        result.header_complete = 1'b0;
        result.option_complete = 1'b0;
        result.error_kind      = coap_opt_pkg::ERR_NONE;

        if (error_eff)
        begin
            result.byte_class = coap_opt_pkg::CLS_DISCARD;
        end
        else
        begin
            case (phase_eff)
                coap_opt_pkg::PH_HEADER:
                begin
                    if (dn == coap_opt_pkg::NIB_RSVD || ln == coap_opt_pkg::NIB_RSVD)
                    begin
                        raise = 1'b1;
                        kind  = coap_opt_pkg::ERR_RESERVED;
                    end
                    else
                    begin
                        len_nib_next = ln;
                        lnib         = ln;
                        if (dn < coap_opt_pkg::NIB_EXT_ONE)
                        begin
                            fin_delta = {13'd0, dn};
                            len_stage = 1'b1;
                        end
                        else if (dn == coap_opt_pkg::NIB_EXT_ONE)
                        begin
                            phase_next = coap_opt_pkg::PH_DEXT1;
                        end
                        else
                        begin
                            phase_next = coap_opt_pkg::PH_DEXT_HI;
                        end
                    end
                end
                coap_opt_pkg::PH_DEXT1:
                begin
                    fin_delta = {9'd0, item.data_byte} + coap_opt_pkg::EXT_ONE_BIAS;
                    len_stage = 1'b1;
                end
                coap_opt_pkg::PH_DEXT_HI:
                begin
                    ext_high_next = item.data_byte;
                    phase_next    = coap_opt_pkg::PH_DEXT_LO;
                end
                coap_opt_pkg::PH_DEXT_LO:
                begin
                    fin_delta = {1'b0, ext_high_reg, item.data_byte}
                              + coap_opt_pkg::EXT_TWO_BIAS;
                    len_stage = 1'b1;
                end
                coap_opt_pkg::PH_LEXT1:
                begin
                    fin_len = {9'd0, item.data_byte} + coap_opt_pkg::EXT_ONE_BIAS;
                    fin     = 1'b1;
                end
                coap_opt_pkg::PH_LEXT_HI:
                begin
                    ext_high_next = item.data_byte;
                    phase_next    = coap_opt_pkg::PH_LEXT_LO;
                end
                coap_opt_pkg::PH_LEXT_LO:
                begin
                    fin_len = {1'b0, ext_high_reg, item.data_byte}
                            + coap_opt_pkg::EXT_TWO_BIAS;
                    fin     = 1'b1;
                end
                coap_opt_pkg::PH_VALUE:
                begin
                    result.byte_class    = coap_opt_pkg::CLS_VALUE;
                    result.option_number = running_eff;
                    result.option_length = pend_len_reg;
                    remain_next          = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        result.option_complete = 1'b1;
                        phase_next             = coap_opt_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = coap_opt_pkg::PH_HEADER;
                end
            endcase

            // length nibble once the delta is known
            if (len_stage)
            begin
                pend_delta_next = fin_delta;
                if (lnib < coap_opt_pkg::NIB_EXT_ONE)
                begin
                    fin_len = {13'd0, lnib};
                    fin     = 1'b1;
                end
                else if (lnib == coap_opt_pkg::NIB_EXT_ONE)
                begin
                    phase_next = coap_opt_pkg::PH_LEXT1;
                end
                else
                begin
                    phase_next = coap_opt_pkg::PH_LEXT_HI;
                end
            end

            // header done: add delta, check the 16-bit range
            if (fin)
            begin
                sum = {2'd0, running_eff} + {1'b0, fin_delta};
                if (sum > coap_opt_pkg::NUM_MAX || fin_len > coap_opt_pkg::LEN_MAX)
                begin
                    raise = 1'b1;
                    kind  = coap_opt_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    running_next           = sum[15:0];
                    remain_next            = fin_len[15:0];
                    pend_len_next          = fin_len[15:0];
                    result.header_complete = 1'b1;
                    result.option_number   = sum[15:0];
                    result.option_length   = fin_len[15:0];
                    if (fin_len == 17'd0)
                    begin
                        result.option_complete = 1'b1;
                        phase_next             = coap_opt_pkg::PH_HEADER;
                    end
                    else
                    begin
                        phase_next = coap_opt_pkg::PH_VALUE;
                    end
                end
            end

            // buffer ends inside an option
            if (!raise && item.last_of_buffer && phase_next != coap_opt_pkg::PH_HEADER)
            begin
                raise = 1'b1;
                kind  = coap_opt_pkg::ERR_TRUNCATED;
            end

            if (raise)
            begin
                result.byte_class      = coap_opt_pkg::CLS_ERROR;
                result.error_kind      = kind;
                result.option_number   = 16'd0;
                result.option_length   = 16'd0;
                result.header_complete = 1'b0;
                result.option_complete = 1'b0;
                error_next             = 1'b1;
                phase_next             = coap_opt_pkg::PH_HEADER;
            end
        end
    end

    // parser state, advanced once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= coap_opt_pkg::PH_HEADER;
            running_reg    <= 16'd0;
            pend_delta_reg <= 17'd0;
            pend_len_reg   <= 16'd0;
            len_nib_reg    <= 4'd0;
            ext_high_reg   <= 8'd0;
            remain_reg     <= 16'd0;
            error_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            running_reg    <= running_next;
            pend_delta_reg <= pend_delta_next;
            pend_len_reg   <= pend_len_next;
            len_nib_reg    <= len_nib_next;
            ext_high_reg   <= ext_high_next;
            remain_reg     <= remain_next;
            error_reg      <= error_next;
        end
    end

    assign status.error_seen   = error_reg;
    assign status.phase_header = (phase_reg == coap_opt_pkg::PH_HEADER);

endmodule
